// ===== rtl/core/tbvs_pkg.sv =====
// Shared types, constants and helpers for the two-body Verlet step unit.
// Used by the controller, the datapath and the top level. No dependencies.
package tbvs_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned POS_W = 32;
  localparam int unsigned MASS_W = 31;
  localparam int unsigned CNT_W = 20;
  localparam int unsigned WIDE_W = 68;
  localparam int unsigned IN_DATA_W = 128;
  localparam int unsigned OUT_DATA_W = 152;

  localparam logic [MASS_W-1:0] MASS_ONE_RST = 31'd65536;
  localparam logic [MASS_W-1:0] MASS_TWO_RST = 31'd131072;
  localparam logic [POS_W-1:0] TIME_STEP_RST = 32'd655;
  localparam logic [CNT_W-1:0] STEP_LIMIT_RST = 20'd9999;

  // configuration register indexes
  localparam logic [1:0] REG_MASS_ONE = 2'd0;
  localparam logic [1:0] REG_MASS_TWO = 2'd1;
  localparam logic [1:0] REG_TIME_STEP = 2'd2;
  localparam logic [1:0] REG_STEP_LIMIT = 2'd3;

  // input operation codes
  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_STEP = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_COLL, ST_SQ1, ST_SQ2, ST_ROOT_GO, ST_ROOT,
    ST_U_GO, ST_U, ST_MASS, ST_ALOAD, ST_PP, ST_MD_GO, ST_MD,
    ST_VH, ST_PRIME, ST_ADV, ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIFF, OP_COLL, OP_SQ0, OP_SQ1, OP_SQ2, OP_SQRT,
    OP_UDIV, OP_USTORE, OP_MASS, OP_ALOAD, OP_PP, OP_MDIV, OP_XSTORE,
    OP_XCAP, OP_VH, OP_PRIME, OP_ADV, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
    logic [2:0] pp;
  } cmd_t;

  typedef struct packed {
    logic run_done;
    logic coincide;
    logic primed;
    logic sqrt_busy;
    logic div_busy;
    logic cap;
    logic out_free;
  } stat_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== rtl/core/two_body_verlet_step_unit.sv =====
// Two-body planar gravity integrator, position Verlet in fixed point.
// Top level: controller plus datapath. Depends on tbvs_pkg, tbvs_ctrl, tbvs_dpath.
//
// Usage:
//  - Slave stream carries one word per item. tuser[0] selects load (0) or step (1),
//    tuser[1] names the body a load sets. tdata holds pos_x, pos_y, vel_x, vel_y.
//  - A load returns nothing; it clears the priming flag and
//    the step counter.
//  - A step returns one master word with step index and both new positions;
//    tuser flags coincident bodies (state held), tlast marks the last step of a
//    run. Steps past the limit return nothing.
//  - A step runs a square root, two divisions for the unit vector and up to
//    four divisions for the force terms (a capped term skips its division);
//    the divisions share one divider. A collision step skips the root and
//    all divisions.
//  - One item is in work at a time; s_axis_tready is high only when idle.
//  - The result sits in an output register; a stalled receiver holds the word
//    and the next finished step waits until that register is free.
//  - Reset clears positions, velocities, counter and loads register defaults.
//  - Configuration writes are always accepted and must come only while idle.
module two_body_verlet_step_unit #(
  parameter int unsigned FRAC_BITS = tbvs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y
  input  logic [tbvs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation, body
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // step_index, one_x, one_y, two_x, two_y, zero fill
  output logic [tbvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // collide_error
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_addr_i,
  input  logic [31:0]                     cfg_data_i
);
  import tbvs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tbvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_oper_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbvs_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .load_body_i (s_axis_tuser[1]),
    .load_data_i (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/tbvs_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Stand-alone unit, used by the datapath; no package dependency.
module tbvs_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [35:0] rem_s;
  logic [35:0] trial;

  assign rem_s = {rem_q, rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 5'd31;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (rem_s >= trial) begin
        rem_d  = 34'(rem_s - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_s[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/tbvs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Starts from a partial remainder below the divisor; no package dependency.
module tbvs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] rem_i,
  input  logic [63:0] num_i,
  input  logic [62:0] den_i,
  input  logic [6:0]  iters_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);

  logic [62:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [63:0] quot_q, quot_d;
  logic [62:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [63:0] t;

  assign t = {rem_q, num_q[63]};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = rem_i;
      num_d  = num_i;
      quot_d = '0;
      den_d  = den_i;
      cnt_d  = iters_i - 7'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        rem_d  = 63'(t - {1'b0, den_q});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = t[62:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/tbvs_dpath.sv =====
// Datapath: body state, config registers, shared 32x32 multiplier, sqrt and
// divider units, output word register. Depends on tbvs_pkg, tbvs_sqrt, tbvs_div.
module tbvs_dpath #(
  parameter int unsigned FRAC_BITS = tbvs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tbvs_pkg::cmd_t                     cmd_i,
  output tbvs_pkg::stat_t                    stat_o,
  input  logic                               load_body_i,
  input  logic [tbvs_pkg::IN_DATA_W-1:0]     load_data_i,
  input  logic                               cfg_valid_i,
  input  logic [1:0]                         cfg_addr_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [tbvs_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic                               out_err_o,
  output logic                               out_last_o
);
  import tbvs_pkg::*;

  localparam int unsigned U_W = FRAC_BITS + 1;

  logic signed [POS_W-1:0] cur_q [4];
  logic signed [POS_W-1:0] prev_q [4];
  logic signed [POS_W-1:0] vel_q [4];
  logic                    primed_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [MASS_W-1:0]       m1_q, m2_q;
  logic signed [POS_W-1:0] h_q;
  logic [CNT_W-1:0]        lim_q;

  logic [30:0]  dmag_q [2];
  logic         dneg_q [2];
  logic         dpos_q [2];
  logic [63:0]  prod_q;
  logic [62:0]  d2_q, hsq_q;
  logic [U_W-1:0] u_q [2];
  logic [61:0]  a_q;
  logic [127:0] acc_q;
  logic [62:0]  x_q [4];

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_err_q, out_last_q;

  logic [1:0]  idx;
  logic [31:0] hmag, vmag;
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic        out_free;

  assign idx = cmd_i.idx;
  assign hmag = h_q[31] ? 32'(-h_q) : 32'(h_q);
  assign vmag = vel_q[idx][31] ? 32'(-vel_q[idx]) : 32'(vel_q[idx]);
  assign out_free = !out_valid_q || out_ready_i;

  // saturated differences between the two bodies
  logic signed [32:0] dfx, dfy;
  logic [32:0] afx, afy;
  logic [30:0] mfx, mfy;
  assign dfx = 33'(cur_q[0]) - 33'(cur_q[2]);
  assign dfy = 33'(cur_q[1]) - 33'(cur_q[3]);
  assign afx = dfx[32] ? 33'(-dfx) : 33'(dfx);
  assign afy = dfy[32] ? 33'(-dfy) : 33'(dfy);
  assign mfx = (afx > 33'h07fffffff) ? 31'h7fffffff : afx[30:0];
  assign mfy = (afy > 33'h07fffffff) ? 31'h7fffffff : afy[30:0];

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_SQ0: begin
        mul_a = 32'(dmag_q[0]);
        mul_b = 32'(dmag_q[0]);
      end
      OP_SQ1: begin
        mul_a = 32'(dmag_q[1]);
        mul_b = 32'(dmag_q[1]);
      end
      OP_SQ2: begin
        mul_a = hmag;
        mul_b = hmag;
      end
      OP_MASS: begin
        mul_a = idx[1] ? 32'(m1_q) : 32'(m2_q);
        mul_b = 32'(u_q[idx[0]]);
      end
      OP_PP: begin
        mul_a = cmd_i.pp[1] ? {2'b00, a_q[61:32]} : a_q[31:0];
        mul_b = cmd_i.pp[0] ? {1'b0, hsq_q[62:32]} : hsq_q[31:0];
        mul_en = (cmd_i.pp != 3'd4);
      end
      OP_VH: begin
        mul_a = vmag;
        mul_b = hmag;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // partial product weight of the previous cycle's product
  logic [2:0]   pp_prev;
  logic [6:0]   pp_sh;
  assign pp_prev = cmd_i.pp - 3'd1;
  always_comb begin
    case (pp_prev)
      3'd0:    pp_sh = 7'd0;
      3'd3:    pp_sh = 7'd64;
      default: pp_sh = 7'd32;
    endcase
  end

  // divider and root units
  logic        sqrt_busy;
  logic [31:0] root;
  logic        div_start, div_busy;
  logic [62:0] div_rem;
  logic [63:0] div_num, quot;
  logic [62:0] div_den;
  logic [6:0]  div_iters;

  tbvs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT),
    .rad_i   ({1'b0, d2_q}),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_num   = 64'(dmag_q[idx[0]]) << FRAC_BITS;
    div_den   = {31'b0, root};
    div_iters = 7'd64;
    if (cmd_i.op == OP_UDIV) begin
      div_start = 1'b1;
    end else if (cmd_i.op == OP_MDIV) begin
      div_start = 1'b1;
      div_rem   = acc_q[124:62];
      div_num   = {acc_q[61:0], 2'b00};
      div_den   = d2_q;
      div_iters = 7'd62;
    end
  end

  tbvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // per-element update sums
  logic signed [WIDE_W-1:0] cur_w, prev_w, vh_w, half_w, term_w;
  logic [63:0] vh_mag;
  logic [62:0] half_mag, term_mag;
  logic        eneg, vneg;
  logic signed [POS_W-1:0] prime_val, adv_val;

  assign eneg = idx[1] ? dneg_q[idx[0]] : dpos_q[idx[0]];
  assign vneg = vel_q[idx][31] ^ h_q[31];
  assign vh_mag = prod_q >> FRAC_BITS;
  assign half_mag = x_q[idx] >> (FRAC_BITS + 1);
  assign term_mag = x_q[idx] >> FRAC_BITS;
  assign cur_w = WIDE_W'(cur_q[idx]);
  assign prev_w = WIDE_W'(prev_q[idx]);
  assign vh_w = vneg ? -$signed({4'b0, vh_mag}) : $signed({4'b0, vh_mag});
  assign half_w = eneg ? -$signed({5'b0, half_mag}) : $signed({5'b0, half_mag});
  assign term_w = eneg ? -$signed({5'b0, term_mag}) : $signed({5'b0, term_mag});
  assign prime_val = sat32(cur_w - vh_w + half_w);
  assign adv_val = sat32((cur_w <<< 1) - prev_w + term_w);

  logic [CNT_W-1:0] cnt_inc;
  assign cnt_inc = cnt_q + CNT_W'(1);

  // control-side state and body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        cur_q[i]  <= '0;
        prev_q[i] <= '0;
        vel_q[i]  <= '0;
      end
      primed_q    <= 1'b0;
      cnt_q       <= '0;
      m1_q        <= MASS_ONE_RST;
      m2_q        <= MASS_TWO_RST;
      h_q         <= TIME_STEP_RST;
      lim_q       <= STEP_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          REG_MASS_ONE:   m1_q <= cfg_data_i[MASS_W-1:0];
          REG_MASS_TWO:   m2_q <= cfg_data_i[MASS_W-1:0];
          REG_TIME_STEP:  h_q <= cfg_data_i;
          REG_STEP_LIMIT: lim_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          cur_q[{load_body_i, 1'b0}] <= load_data_i[31:0];
          cur_q[{load_body_i, 1'b1}] <= load_data_i[63:32];
          vel_q[{load_body_i, 1'b0}] <= load_data_i[95:64];
          vel_q[{load_body_i, 1'b1}] <= load_data_i[127:96];
          primed_q <= 1'b0;
          cnt_q    <= '0;
        end
        OP_PRIME: prev_q[idx] <= prime_val;
        OP_ADV: begin
          prev_q[idx] <= cur_q[idx];
          cur_q[idx]  <= adv_val;
        end
        OP_EMIT: begin
          cnt_q       <= cnt_inc;
          primed_q    <= 1'b1;
          out_valid_q <= 1'b1;
        end
        OP_COLL: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
    end
    case (cmd_i.op)
      OP_DIFF: begin
        dmag_q[0] <= mfx;
        dmag_q[1] <= mfy;
        dneg_q[0] <= dfx[32];
        dneg_q[1] <= dfy[32];
        dpos_q[0] <= !dfx[32] && (dfx != '0);
        dpos_q[1] <= !dfy[32] && (dfy != '0);
      end
      OP_SQ1:    d2_q <= prod_q[62:0];
      OP_SQ2:    d2_q <= d2_q + prod_q[62:0];
      OP_SQRT:   hsq_q <= prod_q[62:0];
      OP_USTORE: u_q[idx[0]] <= quot[U_W-1:0];
      OP_ALOAD: begin
        a_q   <= prod_q[61:0];
        acc_q <= '0;
      end
      OP_PP: begin
        if (cmd_i.pp != 3'd0) begin
          acc_q <= acc_q + (128'(prod_q) << pp_sh);
        end
      end
      OP_XSTORE: x_q[idx] <= quot[62:0];
      OP_XCAP:   x_q[idx] <= 63'h4000000000000000;
      default: ;
    endcase
    if (out_free && (cmd_i.op == OP_EMIT)) begin
      out_data_q <= {4'b0, cur_q[3], cur_q[2], cur_q[1], cur_q[0], cnt_inc};
      out_err_q  <= 1'b0;
      out_last_q <= (cnt_inc == lim_q);
    end else if (out_free && (cmd_i.op == OP_COLL)) begin
      out_data_q <= {4'b0, cur_q[3], cur_q[2], cur_q[1], cur_q[0], cnt_inc};
      out_err_q  <= 1'b1;
      out_last_q <= 1'b0;
    end
  end

  assign stat_o = '{
    run_done:  (cnt_q >= lim_q),
    coincide:  (dmag_q[0] == '0) && (dmag_q[1] == '0),
    primed:    primed_q,
    sqrt_busy: sqrt_busy,
    div_busy:  div_busy,
    cap:       (acc_q[127:62] >= {3'b0, d2_q}),
    out_free:  out_free
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/core/tbvs_ctrl.sv =====
// Controller state machine: sequences one load or one time step through the
// datapath by command words. Depends on tbvs_pkg.
module tbvs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_oper_i,
  output logic            in_ready_o,
  input  tbvs_pkg::stat_t stat_i,
  output tbvs_pkg::cmd_t  cmd_o
);
  import tbvs_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] pp_q, pp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pp_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pp_q    <= pp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pp_d       = pp_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, idx: idx_q, pp: pp_q};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_oper_i == OPER_LOAD) begin
            cmd_o.op = OP_LOAD;
          end else if (!stat_i.run_done) begin
            cmd_o.op = OP_DIFF;
            state_d  = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (stat_i.coincide) begin
          state_d = ST_COLL;
        end else begin
          cmd_o.op = OP_SQ0;
          state_d  = ST_SQ1;
        end
      end
      ST_COLL: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_COLL;
          state_d  = ST_IDLE;
        end
      end
      ST_SQ1: begin
        cmd_o.op = OP_SQ1;
        state_d  = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.op = OP_SQ2;
        state_d  = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd_o.op = OP_SQRT;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (!stat_i.sqrt_busy) begin
          idx_d   = 2'd0;
          state_d = ST_U_GO;
        end
      end
      ST_U_GO: begin
        cmd_o.op = OP_UDIV;
        state_d  = ST_U;
      end
      ST_U: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_USTORE;
          if (idx_q[0]) begin
            idx_d   = 2'd0;
            state_d = ST_MASS;
          end else begin
            idx_d   = 2'd1;
            state_d = ST_U_GO;
          end
        end
      end
      ST_MASS: begin
        cmd_o.op = OP_MASS;
        state_d  = ST_ALOAD;
      end
      ST_ALOAD: begin
        cmd_o.op = OP_ALOAD;
        pp_d     = 3'd0;
        state_d  = ST_PP;
      end
      // four partial products, each added in the cycle after its product
      ST_PP: begin
        cmd_o.op = OP_PP;
        if (pp_q == 3'd4) begin
          state_d = ST_MD_GO;
        end else begin
          pp_d = pp_q + 3'd1;
        end
      end
      ST_MD_GO: begin
        if (stat_i.cap) begin
          cmd_o.op = OP_XCAP;
          idx_d    = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_d = stat_i.primed ? ST_ADV : ST_VH;
          end else begin
            state_d = ST_MASS;
          end
        end else begin
          cmd_o.op = OP_MDIV;
          state_d  = ST_MD;
        end
      end
      ST_MD: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_XSTORE;
          idx_d    = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_d = stat_i.primed ? ST_ADV : ST_VH;
          end else begin
            state_d = ST_MASS;
          end
        end
      end
      ST_VH: begin
        cmd_o.op = OP_VH;
        state_d  = ST_PRIME;
      end
      ST_PRIME: begin
        cmd_o.op = OP_PRIME;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == 2'd3) ? ST_ADV : ST_VH;
      end
      ST_ADV: begin
        cmd_o.op = OP_ADV;
        idx_d    = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sim/tb_two_body_verlet_step_unit.sv =====
// Self-checking bench for two_body_verlet_step_unit: directed and random loads and steps,
// with a scoreboard class that predicts each step result. Depends on tbvs_pkg and the RTL.
module tb_two_body_verlet_step_unit;
  import tbvs_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [CNT_W-1:0]               step_index;
    logic [3:0][POS_W-1:0]          pos;     // one_x, one_y, two_x, two_y
    logic                           collide;
    logic                           fin;
  } step_word_t;

  class verlet_scoreboard;
    longint cur[4];
    longint prv[4];
    longint vel[4];
    bit primed;
    longint unsigned count;
    longint unsigned m_one, m_two, limit;
    longint h;
    step_word_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        cur[i] = 0;
        prv[i] = 0;
        vel[i] = 0;
      end
      primed = 0;
      count = 0;
      m_one = MASS_ONE_RST;
      m_two = MASS_TWO_RST;
      h = longint'(signed'(TIME_STEP_RST));
      limit = STEP_LIMIT_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MASS_ONE:   m_one = val[30:0];
        REG_MASS_TWO:   m_two = val[30:0];
        REG_TIME_STEP:  h = longint'(signed'(val));
        REG_STEP_LIMIT: limit = val[19:0];
        default: ;
      endcase
    endfunction

    function longint unsigned absval(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint clamp_diff(longint a, longint b);
      longint d;
      d = a - b;
      if (d > 64'sd2147483647) return 64'sd2147483647;
      if (d < -64'sd2147483647) return -64'sd2147483647;
      return d;
    endfunction

    function longint clamp_pos(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // floor(a*b/c) capped at 2^62
    function longint unsigned force_term(longint unsigned a, longint unsigned b,
                                         longint unsigned c);
      logic [127:0] q;
      q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
      if (q > (128'd1 << 62)) return 64'd1 << 62;
      return q[63:0];
    endfunction

    function longint shifted(longint unsigned m, int sh, bit neg);
      longint v;
      v = longint'(m >> sh);
      return neg ? -v : v;
    endfunction

    function void note_input(logic op, logic body, logic [3:0][31:0] f);
      longint d[2], nxt[4];
      longint unsigned d2, root_len, hsq, u, x[4];
      bit neg[4];
      step_word_t w;
      int b;
      if (op == OPER_LOAD) begin
        b = body ? 2 : 0;
        cur[b] = longint'(signed'(f[0]));
        cur[b+1] = longint'(signed'(f[1]));
        vel[b] = longint'(signed'(f[2]));
        vel[b+1] = longint'(signed'(f[3]));
        primed = 0;
        count = 0;
        return;
      end
      if (count >= limit) return;
      d[0] = clamp_diff(cur[0], cur[2]);
      d[1] = clamp_diff(cur[1], cur[3]);
      if (d[0] == 0 && d[1] == 0) begin
        w.step_index = CNT_W'(count + 1);
        for (int i = 0; i < 4; i++) w.pos[i] = cur[i][31:0];
        w.collide = 1;
        w.fin = 0;
        pending.push_back(w);
        return;
      end
      d2 = absval(d[0]) * absval(d[0]) + absval(d[1]) * absval(d[1]);
      root_len = int_sqrt(d2);
      hsq = absval(h) * absval(h);
      for (int i = 0; i < 2; i++) begin
        u = (absval(d[i]) << FB) / root_len;
        x[i] = force_term(m_two * u, hsq, d2);
        neg[i] = d[i] > 0;
        x[2+i] = force_term(m_one * u, hsq, d2);
        neg[2+i] = d[i] < 0;
      end
      if (!primed) begin
        for (int i = 0; i < 4; i++) begin
          longint p;
          p = vel[i] * h;
          prv[i] = clamp_pos(cur[i] - shifted(absval(p), FB, p < 0)
                             + shifted(x[i], FB + 1, neg[i]));
        end
        primed = 1;
      end
      for (int i = 0; i < 4; i++)
        nxt[i] = clamp_pos(2 * cur[i] - prv[i] + shifted(x[i], FB, neg[i]));
      for (int i = 0; i < 4; i++) begin
        prv[i] = cur[i];
        cur[i] = nxt[i];
        w.pos[i] = nxt[i][31:0];
      end
      count = (count + 1) & 64'hFFFFF;
      w.step_index = CNT_W'(count);
      w.collide = 0;
      w.fin = count == limit;
      pending.push_back(w);
    endfunction

    function void check(step_word_t got);
      step_word_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: got %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.step_index !== e.step_index) begin
        $display("%0t step_index: expected %0d actual %0d", $time, e.step_index,
                 got.step_index);
        errors++;
      end
      for (int i = 0; i < 4; i++)
        if (got.pos[i] !== e.pos[i]) begin
          $display("%0t pos[%0d] step %0d: expected %h actual %h", $time, i,
                   e.step_index, e.pos[i], got.pos[i]);
          errors++;
        end
      if (got.collide !== e.collide) begin
        $display("%0t collide_error: expected %b actual %b", $time, e.collide, got.collide);
        errors++;
      end
      if (got.fin !== e.fin) begin
        $display("%0t final_step: expected %b actual %b", $time, e.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_addr_i;
  logic [31:0]           cfg_data_i;

  two_body_verlet_step_unit u_dut (.*);

  verlet_scoreboard sb = new();
  bit steady;
  int hold_request;
  int hold_left;
  longint cycles;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: checks and random stalls, plus a long hold-off on each request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      step_word_t w;
      if (m_axis_tvalid && m_axis_tready) begin
        w.step_index = m_axis_tdata[19:0];
        w.pos[0] = m_axis_tdata[51:20];
        w.pos[1] = m_axis_tdata[83:52];
        w.pos[2] = m_axis_tdata[115:84];
        w.pos[3] = m_axis_tdata[147:116];
        w.collide = m_axis_tuser;
        w.fin = m_axis_tlast;
        sb.check(w);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send_item(logic op, logic body, logic [3:0][31:0] f);
    if (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {body, op};
    s_axis_tdata <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, body, f);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // block goes idle: all words back, then room for a step that returns nothing
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] m1, logic [31:0] m2, logic [31:0] h,
                          logic [31:0] lim);
    settle();
    cfg_write(REG_MASS_ONE, m1);
    cfg_write(REG_MASS_TWO, m2);
    cfg_write(REG_TIME_STEP, h);
    cfg_write(REG_STEP_LIMIT, lim);
  endtask

  function automatic logic [31:0] rand_q(int span);
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(2 * span) - span;
    endcase
  endfunction

  task automatic load_body(logic body, int span);
    send_item(OPER_LOAD, body, {rand_q(span / 8), rand_q(span / 8), rand_q(span), rand_q(span)});
  endtask

  task automatic do_step();
    send_item(OPER_STEP, 1'($urandom_range(1)), {$urandom, $urandom, $urandom, $urandom});
  endtask

  localparam logic [31:0] MX = 32'h7fffffff;
  localparam logic [31:0] MN = 32'h80000000;
  localparam logic [31:0] ONE = 32'h00010000;

  initial begin
    logic [31:0] cfg_m1[6] = '{32'd65536, 32'd0, 32'h7fffffff, 32'd3000, 32'd65536, 32'd200000};
    logic [31:0] cfg_m2[6] = '{32'd131072, 32'h7fffffff, 32'd0, 32'd9000, 32'd65536, 32'd70000};
    logic [31:0] cfg_h[6] = '{32'd655, -32'sd655, 32'h7fffffff, 32'h80000000, 32'd655,
                              32'd4000};
    logic [31:0] cfg_lim[6] = '{32'd9999, 32'hfffff, 32'd40, 32'd5, 32'd0, 32'd12};
    int quota;
    int n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    steady = 0;
    hold_request = 0;
    hold_left = 0;
    cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step on the reset state reports coincident bodies
    do_step();
    send_item(OPER_LOAD, 1'b0, {32'd0, 32'd0, ONE, 32'd5});
    send_item(OPER_LOAD, 1'b1, {32'd0, 32'd0, 32'd0, 32'd5});
    do_step();
    // small limit: priming step, final step, then steps that return nothing
    set_regs(32'd65536, 32'd131072, 32'd655, 32'd3);
    send_item(OPER_LOAD, 1'b0, {32'd0, ONE, 32'd0, ONE});
    send_item(OPER_LOAD, 1'b1, {-32'sd65536 / 2, 32'd0, -32'sd65536, 32'd0});
    repeat (5) do_step();
    set_regs(32'd65536, 32'd131072, 32'd655, 32'd9999);
    // far apart bodies, saturated differences; then coincident bodies at extreme positions
    send_item(OPER_LOAD, 1'b0, {MX, MX, MX, MX});
    send_item(OPER_LOAD, 1'b1, {MN, MN, MN, MN});
    repeat (2) do_step();
    send_item(OPER_LOAD, 1'b0, {MX, MN, MN, MX});
    send_item(OPER_LOAD, 1'b1, {32'd0, 32'd0, MN, MX});
    repeat (2) do_step();

    for (int ph = 0; ph < 6; ph++) begin
      set_regs(cfg_m1[ph], cfg_m2[ph], cfg_h[ph], cfg_lim[ph]);
      steady = ph == 1;
      quota = cfg_lim[ph] == 0 ? 15 : 110;
      n = 0;
      while (n < quota) begin
        if ($urandom_range(9) == 0) begin
          send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                    {$urandom, $urandom, $urandom, $urandom});
          n++;
        end else begin
          load_body(1'b0, 1 << 20);
          load_body(1'b1, 1 << 20);
          n += 2;
          if (ph == 0 && n > 40 && n < 60) hold_request = 3000;
          repeat ($urandom_range(1, 14)) begin
            do_step();
            n++;
          end
        end
      end
      steady = 0;
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tbvs_pkg.sv
rtl/core/tbvs_sqrt.sv
rtl/core/tbvs_div.sv
rtl/core/tbvs_dpath.sv
rtl/core/tbvs_ctrl.sv
rtl/core/two_body_verlet_step_unit.sv
sim/tb_two_body_verlet_step_unit.sv
